// ===== hw/rtl/lpm_pkg.sv =====
// Package for the longest-prefix-match routing table.
// Holds the table size, the request type that moves down the cell chain and the operation codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

	localparam int TABLE_ENTRIES = 64;

	// Width of a slot index inside the chain; never narrower than the entry_index field.
	localparam int IDX_W = (TABLE_ENTRIES > 64) ? $clog2(TABLE_ENTRIES) : 6;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 32;

	typedef enum logic {
		FUNC_WRITE  = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef struct packed {
		func_t            func;
		logic [IDX_W-1:0] entry_index;
		logic             entry_valid;
		logic [31:0]      net_address;
		logic [31:0]      subnet_mask;
		logic [31:0]      next_hop;
		logic [31:0]      dest_address;
		logic [31:0]      best_mask;
		logic [31:0]      best_hop;
		logic             found;
	} lpm_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpm_cell.sv =====
// One cell of the routing table chain: holds a single table slot and one pipeline stage.
// A write stores into the slot when its index matches; a lookup updates the running best match.
// Depends on lpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpm_cell
	import lpm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [IDX_W-1:0] cell_id,
	input  wire logic             in_valid,
	input  wire lpm_req_t         in_req,
	output logic                  out_valid,
	output lpm_req_t              out_req
);

	logic        ent_valid_q;
	logic [31:0] net_q;
	logic [31:0] mask_q;
	logic [31:0] hop_q;

	logic     valid_s1;
	lpm_req_t req_s1;

	logic     hit_write;
	logic     win;
	lpm_req_t next_req;

	assign hit_write = in_valid && (in_req.func == FUNC_WRITE) && (in_req.entry_index == cell_id);

	// Strictly greater mask wins, so an earlier slot keeps a tie and a zero mask never wins.
	assign win = ent_valid_q && (in_req.func == FUNC_LOOKUP)
		&& ((in_req.dest_address & mask_q) == net_q)
		&& (mask_q > in_req.best_mask);

	always_comb begin
		next_req = in_req;
		if (win) begin
			next_req.best_mask = mask_q;
			next_req.best_hop  = hop_q;
			next_req.found     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			if (hit_write) begin
				ent_valid_q <= in_req.entry_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			req_s1 <= next_req;
			// Removing a slot leaves its contents untouched.
			if (hit_write && in_req.entry_valid) begin
				net_q  <= in_req.net_address;
				mask_q <= in_req.subnet_mask;
				hop_q  <= in_req.next_hop;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_req   = req_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/longest_prefix_match_table_top.sv =====
// Throughput: one request per cycle; the chain of cells advances whenever the output
// register is empty or being taken, and the whole chain holds while the output stalls.
// Reset clears every slot's valid bit and all stage valid flags; slot contents are
// undefined until written.
// Top level of the longest-prefix-match routing table; depends on lpm_pkg and lpm_cell.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_match_table_top
	import lpm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// entry_index[5:0], entry_valid[6], net_address[38:7], subnet_mask[70:39],
	// next_hop[102:71], dest_address[134:103], zero[135]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// func[0]
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// hop_result[31:0]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// matched[0]
	output logic                       m_tuser
);

	logic     chain_valid [0:TABLE_ENTRIES];
	lpm_req_t chain_req   [0:TABLE_ENTRIES];
	logic     advance;

	assign advance  = !chain_valid[TABLE_ENTRIES] || m_tready;
	assign s_tready = advance;

	always_comb begin
		chain_req[0].func         = func_t'(s_tuser);
		chain_req[0].entry_index  = IDX_W'(s_tdata[5:0]);
		chain_req[0].entry_valid  = s_tdata[6];
		chain_req[0].net_address  = s_tdata[38:7];
		chain_req[0].subnet_mask  = s_tdata[70:39];
		chain_req[0].next_hop     = s_tdata[102:71];
		chain_req[0].dest_address = s_tdata[134:103];
		chain_req[0].best_mask    = 32'd0;
		chain_req[0].best_hop     = 32'd0;
		chain_req[0].found        = 1'b0;
	end
	assign chain_valid[0] = s_tvalid;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		lpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.cell_id   (IDX_W'(i)),
			.in_valid  (chain_valid[i]),
			.in_req    (chain_req[i]),
			.out_valid (chain_valid[i+1]),
			.out_req   (chain_req[i+1])
		);
	end

	assign m_tvalid = chain_valid[TABLE_ENTRIES];
	assign m_tdata  = chain_req[TABLE_ENTRIES].best_hop;
	assign m_tuser  = chain_req[TABLE_ENTRIES].found;

endmodule

`default_nettype wire

// ===== hw/rtl/lpm_checker.sv =====
// Port-level checker for the longest-prefix-match routing table, bound to the top level.
// Depends on lpm_pkg and longest_prefix_match_table_top.
`timescale 1ns / 1ps
`default_nettype none

module lpm_checker
	import lpm_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [IN_DATA_W-1:0]  s_tdata,
	input wire logic                  s_tuser,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tuser
);

	// A waiting request holds still until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("request changed while waiting");

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The input side takes a request exactly when the output register can move.
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output side");

	// A result without a match always reports a zero next hop.
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("unmatched result carries a nonzero next hop");

	// No result is shown in the first cycle after reset is released.
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

endmodule

bind longest_prefix_match_table_top lpm_checker u_lpm_checker (.*);

`default_nettype wire

// ===== tb/longest_prefix_match_table_top_tb.sv =====
// Self-checking testbench for the longest-prefix-match routing table top level.
// A scoreboard class keeps its own copy of the table and predicts each result in order;
// depends on lpm_pkg and longest_prefix_match_table_top.
`timescale 1ns / 1ps

module longest_prefix_match_table_top_tb
	import lpm_pkg::*;
();

	typedef struct {
		func_t       func;
		logic [5:0]  entry_index;
		logic        entry_valid;
		logic [31:0] net_address;
		logic [31:0] subnet_mask;
		logic [31:0] next_hop;
		logic [31:0] dest_address;
	} route_req_t;

	class route_scoreboard;
		logic [31:0] net_tbl[TABLE_ENTRIES];
		logic [31:0] mask_tbl[TABLE_ENTRIES];
		logic [31:0] hop_tbl[TABLE_ENTRIES];
		bit          valid_tbl[TABLE_ENTRIES];
		logic [31:0] hop_q[$];
		bit          match_q[$];
		int unsigned errors;
		int unsigned writes;
		int unsigned removals;
		int unsigned lookups;
		int unsigned hits;

		function new();
			foreach (valid_tbl[i])
				valid_tbl[i] = 1'b0;
			errors = 0;
			writes = 0;
			removals = 0;
			lookups = 0;
			hits = 0;
		endfunction

		function int pending();
			return hop_q.size();
		endfunction

		task report(input string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// Applies a write to the table copy, or resolves a lookup against it, and queues the expected result of either.
		function void note_request(input route_req_t r);
			logic [31:0] best_mask;
			logic [31:0] best_hop;
			bit          found;
			best_mask = 32'h0;
			best_hop = 32'h0;
			found = 1'b0;
			if (r.func == FUNC_WRITE) begin
				writes++;
				if (r.entry_index < TABLE_ENTRIES) begin
					if (r.entry_valid) begin
						net_tbl[r.entry_index] = r.net_address;
						mask_tbl[r.entry_index] = r.subnet_mask;
						hop_tbl[r.entry_index] = r.next_hop;
						valid_tbl[r.entry_index] = 1'b1;
					end else begin
						// Only the valid bit goes; the stored fields stay as they were.
						valid_tbl[r.entry_index] = 1'b0;
						removals++;
					end
				end
			end else begin
				lookups++;
				// A strict greater-than keeps the lowest index on equal masks and
				// means a zero mask can never win.
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (valid_tbl[i] && ((r.dest_address & mask_tbl[i]) == net_tbl[i]) &&
					    mask_tbl[i] > best_mask) begin
						best_mask = mask_tbl[i];
						best_hop = hop_tbl[i];
						found = 1'b1;
					end
				end
				if (found)
					hits++;
			end
			hop_q = {hop_q, best_hop};
			match_q = {match_q, found};
		endfunction

		task check_result(input logic [31:0] hop, input logic matched);
			logic [31:0] exp_hop;
			bit          exp_match;
			if (hop_q.size() == 0) begin
				report($sformatf("result hop=%h matched=%b with no request pending", hop, matched));
				return;
			end
			exp_hop = hop_q.pop_front();
			exp_match = match_q.pop_front();
			if (hop !== exp_hop)
				report($sformatf("hop_result %h, expected %h", hop, exp_hop));
			if (matched !== exp_match)
				report($sformatf("matched %b, expected %b", matched, exp_match));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = FUNC_WRITE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	int send_idle = 20;
	int recv_idle = 57;

	route_scoreboard sb;

	// Shared bases make random prefixes nest and overlap at many lengths.
	logic [31:0] base_pool[4] = '{32'h0A010203, 32'hC0A80A01, 32'hAC10FF00, 32'hFFFFFFFF};

	longest_prefix_match_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Holds the request until accepted, then maybe idles; valid is lowered only for a gap.
	task automatic send_request(input route_req_t r);
		s_tvalid <= 1'b1;
		s_tuser <= r.func;
		s_tdata <= {1'b0, r.dest_address, r.next_hop, r.subnet_mask, r.net_address,
			r.entry_valid, r.entry_index};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(r);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_entry(input logic [5:0] idx, input logic valid,
			input logic [31:0] net, input logic [31:0] mask, input logic [31:0] hop);
		route_req_t r;
		r.func = FUNC_WRITE;
		r.entry_index = idx;
		r.entry_valid = valid;
		r.net_address = net;
		r.subnet_mask = mask;
		r.next_hop = hop;
		r.dest_address = $urandom;
		send_request(r);
	endtask

	task automatic look_up(input logic [31:0] dest);
		route_req_t r;
		r.func = FUNC_LOOKUP;
		r.entry_index = 6'($urandom);
		r.entry_valid = 1'($urandom);
		r.net_address = $urandom;
		r.subnet_mask = $urandom;
		r.next_hop = $urandom;
		r.dest_address = dest;
		send_request(r);
	endtask

	task automatic run_phase(input int n, input int s_idle, input int r_idle);
		route_req_t  r;
		int          len;
		int          pick;
		logic [31:0] base;
		send_idle = s_idle;
		recv_idle = r_idle;
		repeat (n) begin
			r.func = ($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_LOOKUP;
			r.entry_index = 6'($urandom);
			r.entry_valid = ($urandom_range(99) < 85);
			r.net_address = $urandom;
			r.subnet_mask = $urandom;
			r.next_hop = $urandom;
			r.dest_address = $urandom;
			base = base_pool[$urandom_range(3)];
			if (r.func == FUNC_WRITE) begin
				if ($urandom_range(99) < 90) begin
					len = $urandom_range(32);
					r.subnet_mask = (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
				end
				// The rest keep a random net address, usually with stray bits outside the mask, which can never match.
				if ($urandom_range(99) < 90)
					r.net_address = base & r.subnet_mask;
			end else begin
				pick = $urandom_range(TABLE_ENTRIES - 1);
				case ($urandom_range(2))
					0: begin
						if (sb.valid_tbl[pick])
							r.dest_address = sb.net_tbl[pick] |
								(r.dest_address & ~sb.mask_tbl[pick]);
					end
					1: begin
						r.dest_address = base ^ (r.dest_address >> $urandom_range(31));
					end
					default: begin
					end
				endcase
			end
			send_request(r);
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, then a default route that must never win.
		look_up(32'h00000000);
		look_up(32'hFFFFFFFF);
		write_entry(6'd0, 1'b1, 32'h00000000, 32'h00000000, 32'h11111111);
		look_up(32'h0A000001);
		// Nested prefixes; the most specific one has an all-ones next hop.
		write_entry(6'd5, 1'b1, 32'h0A000000, 32'hFF000000, 32'h0A0000FE);
		write_entry(6'd6, 1'b1, 32'h0A010000, 32'hFFFF0000, 32'h0A0100FE);
		write_entry(6'd7, 1'b1, 32'h0A010200, 32'hFFFFFF00, 32'h00000000);
		write_entry(6'd63, 1'b1, 32'h0A010203, 32'hFFFFFFFF, 32'hFFFFFFFF);
		look_up(32'h0A010203);
		look_up(32'h0A010204);
		look_up(32'h0A01FF00);
		look_up(32'h0AFFFFFF);
		// Equal masks: the lower slot wins until it is removed.
		write_entry(6'd2, 1'b1, 32'h0A010000, 32'hFFFF0000, 32'h22222222);
		look_up(32'h0A01FF00);
		write_entry(6'd2, 1'b0, $urandom, $urandom, $urandom);
		look_up(32'h0A01FF00);
		write_entry(6'd63, 1'b0, $urandom, $urandom, $urandom);
		look_up(32'h0A010203);
		write_entry(6'd9, 1'b1, 32'h0A000001, 32'hFF000000, 32'h00000099);
		look_up(32'h0A000001);
		write_entry(6'd4, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h12345678);
		look_up(32'hFFFFFFFF);
		write_entry(6'd2, 1'b1, 32'hC0A80000, 32'hFFFF0000, 32'hC0A80001);
		look_up(32'hC0A81234);

		run_phase(280, 20, 57);
		run_phase(280, 57, 20);
		run_phase(270, 0, 0);
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TABLE_ENTRIES + 8) @(posedge clk);

		$display("covered %0d writes (%0d removals) and %0d lookups, %0d of which hit,",
			sb.writes, sb.removals, sb.lookups, sb.hits);
		$display("under sender-heavy, receiver-heavy and no idling; %0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
